### rtl/fplw_pkg.sv
`default_nettype none

package fplw_pkg;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_REPLY = 1'b1;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    localparam logic [1:0] LVL_TOP  = 2'd3;
    localparam logic [1:0] LVL_DIR  = 2'd1;
    localparam logic [1:0] LVL_LEAF = 2'd0;

    localparam int PRESENT_BIT = 0;
    localparam int HUGE_BIT    = 7;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef enum logic {
        CMD_START,
        CMD_REPLY
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op     op;
        logic [47:0] vaddr;
        logic [63:0] data;
    } t_cmd;

    typedef struct packed {
        logic        kind;
        logic [63:0] read_addr;
        logic [1:0]  read_level;
        logic [63:0] xlat_addr;
        logic        fault;
    } t_result;

    function automatic logic [8:0] tbl_index(input logic [47:0] va, input logic [1:0] level);
        logic [8:0] idx;
        unique case (level)
            2'd3: idx = va[47:39];
            2'd2: idx = va[38:30];
            2'd1: idx = va[29:21];
            2'd0: idx = va[20:12];
            default: idx = va[20:12];
        endcase
        return idx;
    endfunction

endpackage

`default_nettype wire

### rtl/fplw_ifs.sv
`default_nettype none

interface fplw_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [47:0] lin_addr;
    logic [51:0] root_table;
    logic [63:0] entry_data;

    modport source (output valid, output action, output lin_addr, output root_table,
                    output entry_data, input ready);
    modport sink   (input valid, input action, input lin_addr, input root_table,
                    input entry_data, output ready);
endinterface

interface fplw_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [63:0] read_addr;
    logic [1:0]  read_level;
    logic [63:0] xlat_addr;
    logic        fault;

    modport source (output valid, output kind, output read_addr, output read_level,
                    output xlat_addr, output fault, input ready);
    modport sink   (input valid, input kind, input read_addr, input read_level,
                    input xlat_addr, input fault, output ready);
endinterface

`default_nettype wire

### rtl/fplw_front.sv
`default_nettype none

module fplw_front (
    fplw_in_if.sink        i_req,
    output logic           o_cmd_valid,
    output fplw_pkg::t_cmd o_cmd,
    input  logic           i_cmd_ready
);
    import fplw_pkg::*;

    always_comb begin
        o_cmd_valid = i_req.valid;
        i_req.ready = i_cmd_ready;
        o_cmd.vaddr = i_req.lin_addr;
        if (i_req.action == ACT_START) begin
            o_cmd.op   = CMD_START;
            o_cmd.data = {12'd0, i_req.root_table};
        end else begin
            o_cmd.op   = CMD_REPLY;
            o_cmd.data = i_req.entry_data;
        end
    end
endmodule

`default_nettype wire

### rtl/fplw_queue.sv
`default_nettype none

module fplw_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    input  fplw_pkg::t_cmd i_push_cmd,
    output logic           o_push_ready,
    output logic           o_pop_valid,
    output fplw_pkg::t_cmd o_pop_cmd,
    input  logic           i_pop
);
    import fplw_pkg::*;

    t_cmd             r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr_ptr;
    logic [QAW-1:0]   r_rd_ptr;
    logic [QAW:0]     r_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != QDEPTH[QAW:0]);
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule

`default_nettype wire

### rtl/fplw_back.sv
`default_nettype none

module fplw_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  fplw_pkg::t_cmd i_cmd,
    output logic           o_cmd_pop,
    fplw_out_if.source     o_rsp
);
    import fplw_pkg::*;

    logic        r_busy;
    logic [1:0]  r_level;
    logic [47:0] r_vaddr;
    logic        r_rsp_valid;
    t_result     r_rsp;

    logic        n_busy;
    logic [1:0]  n_level;
    logic [47:0] n_vaddr;
    t_result     n_rsp;
    logic        pop;

    assign pop       = i_cmd_valid && (!r_rsp_valid || o_rsp.ready);
    assign o_cmd_pop = pop;

    always_comb begin
        n_busy  = r_busy;
        n_level = r_level;
        n_vaddr = r_vaddr;
        n_rsp   = '0;
        unique case (i_cmd.op)
            CMD_START: begin
                n_vaddr          = i_cmd.vaddr;
                n_busy           = 1'b1;
                n_level          = LVL_TOP;
                n_rsp.kind       = KIND_READ;
                n_rsp.read_addr  = {i_cmd.data[63:12], tbl_index(i_cmd.vaddr, LVL_TOP), 3'b000};
                n_rsp.read_level = LVL_TOP;
            end
            CMD_REPLY: begin
                n_rsp.kind = KIND_DONE;
                priority if (!r_busy) begin
                    n_rsp.fault = 1'b1;
                end else if (r_level == LVL_DIR && i_cmd.data[HUGE_BIT]) begin
                    n_busy          = 1'b0;
                    n_level         = LVL_LEAF;
                    n_rsp.xlat_addr = {i_cmd.data[63:21], r_vaddr[20:0]};
                end else if (!i_cmd.data[PRESENT_BIT]) begin
                    n_busy      = 1'b0;
                    n_level     = LVL_LEAF;
                    n_rsp.fault = 1'b1;
                end else if (r_level == LVL_LEAF) begin
                    n_busy          = 1'b0;
                    n_rsp.xlat_addr = {i_cmd.data[63:12], r_vaddr[11:0]};
                end else begin
                    n_level          = r_level - 2'd1;
                    n_rsp.kind       = KIND_READ;
                    n_rsp.read_addr  = {i_cmd.data[63:12], tbl_index(r_vaddr, n_level), 3'b000};
                    n_rsp.read_level = n_level;
                end
            end
            default: begin
                n_rsp = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_level     <= LVL_LEAF;
            r_rsp_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_busy      <= n_busy;
                r_level     <= n_level;
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_vaddr <= n_vaddr;
            r_rsp   <= n_rsp;
        end
    end

    assign o_rsp.valid      = r_rsp_valid;
    assign o_rsp.kind       = r_rsp.kind;
    assign o_rsp.read_addr  = r_rsp.read_addr;
    assign o_rsp.read_level = r_rsp.read_level;
    assign o_rsp.xlat_addr  = r_rsp.xlat_addr;
    assign o_rsp.fault      = r_rsp.fault;
endmodule

`default_nettype wire

### rtl/four_level_page_walk.sv
`default_nettype none

// Four-level page-table walker for 48-bit virtual addresses. Each input word is either a
// translate request or a table entry returned by memory, and each gives exactly one output
// word: a read request for the next table entry or a finished translation. The block takes
// one word per cycle while the command queue has room; a word passes the four-entry command
// queue and then the output register, where its result is offered until it is taken. While
// the output register is held, the queue still takes up to four more words before the input
// stalls.

module four_level_page_walk (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fplw_in_if.sink    i_req,
    fplw_out_if.source o_rsp
);
    import fplw_pkg::*;

    logic fq_valid;
    t_cmd fq_cmd;
    logic fq_ready;
    logic qb_valid;
    t_cmd qb_cmd;
    logic qb_pop;

    fplw_front u_front (
        .i_req       (i_req),
        .o_cmd_valid (fq_valid),
        .o_cmd       (fq_cmd),
        .i_cmd_ready (fq_ready)
    );

    fplw_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fq_valid),
        .i_push_cmd   (fq_cmd),
        .o_push_ready (fq_ready),
        .o_pop_valid  (qb_valid),
        .o_pop_cmd    (qb_cmd),
        .i_pop        (qb_pop)
    );

    fplw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (qb_valid),
        .i_cmd       (qb_cmd),
        .o_cmd_pop   (qb_pop),
        .o_rsp       (o_rsp)
    );

    a_done_has_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.kind == KIND_DONE) |-> (o_rsp.read_addr == '0 &&
        o_rsp.read_level == LVL_LEAF))
        else $error("finished translation carries a read address");

    a_read_has_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.kind == KIND_READ) |-> (o_rsp.xlat_addr == '0 && !o_rsp.fault))
        else $error("read request carries a translation result");

    a_fault_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.fault) |-> (o_rsp.kind == KIND_DONE && o_rsp.xlat_addr == '0))
        else $error("fault result with a non-zero address");
endmodule

`default_nettype wire
